/* rtl/core/route_table_insertion_lru_core_assert.svh */
// Assertion macros for the route table core checker.
// Depends on nothing; included by the checker file only.
`ifndef ROUTE_TABLE_INSERTION_LRU_CORE_ASSERT_SVH
`define ROUTE_TABLE_INSERTION_LRU_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define RTIL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define RTIL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rtil_pkg.sv */
// Shared types and constants for the route table core.
// No dependencies; imported by the core and its checker.
package rtil_pkg;

  localparam int RTIL_ENTRIES_DEF = 8;

  localparam int RTIL_ADDR_W = 32;
  localparam int RTIL_HOPS_W = 8;
  localparam int RTIL_SEQ_W  = 32;
  localparam int RTIL_FUNC_W = 2;

  // Beat layouts on the stream ports
  localparam int RTIL_S_DATA_W = 104;
  localparam int RTIL_M_DATA_W = 72;
  localparam int RTIL_M_USER_W = 2;

  localparam logic [RTIL_FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [RTIL_FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [RTIL_FUNC_W-1:0] FUNC_REMOVE = 2'd2;
  localparam logic [RTIL_FUNC_W-1:0] FUNC_FLUSH  = 2'd3;

  typedef struct packed {
    logic [RTIL_SEQ_W-1:0]  seq;
    logic [RTIL_HOPS_W-1:0] hops;
    logic [RTIL_ADDR_W-1:0] next_hop;
    logic [RTIL_ADDR_W-1:0] dest;
  } route_entry_t;

endpackage

/* rtl/core/rtil_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rtil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/route_table_insertion_lru_core.sv */
// Route table core: a small table of routes keyed by destination address,
// replaced in insertion order, with add, lookup, remove and flush commands.
// Depends on rtil_pkg and rtil_ram.
//
// One command is taken at a time. Add, lookup and remove pass through the
// scan, tail, update and result states: the routes sit in a single-read-port
// entry RAM, so the key is compared against one stored destination per cycle,
// then the tail state closes the scan, the update state applies the change (age
// ranks, valid bits, RAM write) and the result state loads the output register
// once it is free. Flush skips the scan and goes straight to the update state.
// The result beat sits in an output register, so the next command beat is taken
// as soon as a result is loaded, even while the downstream side still stalls.
// Ages are kept as a rank per slot (0 newest); an add of a present destination
// rewrites it and makes it newest, an add to a full table evicts the slot of the
// highest rank.
module route_table_insertion_lru_core
  import rtil_pkg::*;
#(
  parameter int TABLE_ENTRIES = RTIL_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // Command side
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // dest_addr[31:0], next_hop_addr[63:32], hops[71:64], seq_number[103:72]
  input  logic [RTIL_S_DATA_W-1:0] s_tdata,
  // func[1:0]
  input  logic [RTIL_FUNC_W-1:0]   s_tuser,
  // Result side
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // route_next_hop[31:0], route_hops[39:32], route_seq[71:40]
  output logic [RTIL_M_DATA_W-1:0] m_tdata,
  // found[0], evicted[1]
  output logic [RTIL_M_USER_W-1:0] m_tuser
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int LW = IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [LW-1:0] ALL_LIMIT = LW'(TABLE_ENTRIES);
  localparam int EW = $bits(route_entry_t);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_TAIL   = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state;

  // Held command
  logic [RTIL_FUNC_W-1:0] op;
  route_entry_t           req;

  // Scan bookkeeping
  logic [IW-1:0] scan_cnt;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] hit_rank;
  route_entry_t  hit_data;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] old_idx;

  // Per-slot state
  logic [TABLE_ENTRIES-1:0] valid;
  logic [IW-1:0]            rank [TABLE_ENTRIES];

  // Entry RAM
  logic         ram_wr_en;
  logic         ram_rd_en;
  logic [EW-1:0] ram_rd_data;
  route_entry_t rd_entry;

  logic          cmp_hit;
  logic          cmp_free;
  logic          cmp_old;
  logic [IW-1:0] upd_idx;
  logic [LW-1:0] upd_limit;
  logic          accept;
  logic          out_load;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_RESULT) && (!m_tvalid || m_tready);

  assign rd_entry  = route_entry_t'(ram_rd_data);
  assign ram_rd_en = (state == ST_SCAN);
  assign ram_wr_en = (state == ST_UPDATE) && (op == FUNC_ADD);

  rtil_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (upd_idx),
    .wr_data (req),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_cnt),
    .rd_data (ram_rd_data)
  );

  // Compare the slot read last cycle against the key
  always_comb begin
    cmp_hit  = rd_vld && valid[rd_idx] && (rd_entry.dest == req.dest);
    cmp_free = rd_vld && !valid[rd_idx];
    cmp_old  = rd_vld && valid[rd_idx] && (rank[rd_idx] == LAST_IDX);
  end

  // Pick the slot an add writes and how far the younger ranks age
  always_comb begin
    if (hit) begin
      upd_idx   = hit_idx;
      upd_limit = {1'b0, hit_rank};
    end else if (free_found) begin
      upd_idx   = free_idx;
      upd_limit = ALL_LIMIT;
    end else begin
      upd_idx   = old_idx;
      upd_limit = {1'b0, LAST_IDX};
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_cnt   <= '0;
      rd_vld     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      m_tvalid   <= 1'b0;
      valid      <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      rd_vld <= (state == ST_SCAN);

      if (cmp_hit && !hit) begin
        hit <= 1'b1;
      end
      if (cmp_free && !free_found) begin
        free_found <= 1'b1;
      end

      // Load a fresh beat, else drop the one taken downstream
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            hit        <= 1'b0;
            free_found <= 1'b0;
            scan_cnt   <= '0;
            state      <= (s_tuser == FUNC_FLUSH) ? ST_UPDATE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one RAM read a cycle; the compare works on the registered read data
          if (scan_cnt == LAST_IDX) begin
            state <= ST_TAIL;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        ST_TAIL: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          case (op)
            FUNC_ADD: begin
              for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (valid[i] && (IW'(i) != upd_idx) && ({1'b0, rank[i]} < upd_limit)) begin
                  rank[i] <= rank[i] + 1'b1;
                end
              end
              rank[upd_idx]  <= '0;
              valid[upd_idx] <= 1'b1;
            end
            FUNC_REMOVE: begin
              if (hit) begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                  if (valid[i] && (rank[i] > hit_rank)) begin
                    rank[i] <= rank[i] - 1'b1;
                  end
                end
                rank[hit_idx]  <= '0;
                valid[hit_idx] <= 1'b0;
              end
            end
            FUNC_FLUSH: begin
              valid <= '0;
              for (int i = 0; i < TABLE_ENTRIES; i++) begin
                rank[i] <= '0;
              end
            end
            default: begin
              // lookup leaves the table untouched
            end
          endcase
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          // Hold until the output register is free, then load the beat
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx <= scan_cnt;
    if (accept) begin
      op  <= s_tuser;
      req <= route_entry_t'(s_tdata);
    end
    if (cmp_hit && !hit) begin
      hit_idx  <= rd_idx;
      hit_rank <= rank[rd_idx];
      hit_data <= rd_entry;
    end
    if (cmp_free && !free_found) begin
      free_idx <= rd_idx;
    end
    if (cmp_old) begin
      old_idx <= rd_idx;
    end
    if (out_load) begin
      m_tuser[0] <= hit;
      m_tuser[1] <= (op == FUNC_ADD) && !hit && !free_found;
      if ((op == FUNC_LOOKUP) && hit) begin
        m_tdata <= {hit_data.seq, hit_data.hops, hit_data.next_hop};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

/* rtl/core/rtil_checker.sv */
// Port-level checker for the route table core, bound to the core module.
// Depends on rtil_pkg and route_table_insertion_lru_core_assert.svh.
`include "route_table_insertion_lru_core_assert.svh"

module rtil_checker
  import rtil_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [RTIL_S_DATA_W-1:0] s_tdata,
  input logic [RTIL_FUNC_W-1:0]   s_tuser,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [RTIL_M_DATA_W-1:0] m_tdata,
  input logic [RTIL_M_USER_W-1:0] m_tuser
);

  // A stalled result beat holds
  `RTIL_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // Route fields are zero unless the destination was found
  `RTIL_ASSERT_NOW(a_zero_miss, clk, rst, m_tvalid && !m_tuser[0], m_tdata == '0, "route fields set on a miss")

  // An eviction only happens when the destination was absent
  `RTIL_ASSERT_NOW(a_evict_miss, clk, rst, m_tvalid && m_tuser[1], !m_tuser[0], "eviction flagged on a hit")

  // One command at a time: busy after a command beat
  `RTIL_ASSERT_NEXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready, "command taken while busy")

endmodule

bind route_table_insertion_lru_core rtil_checker u_rtil_checker (.*);
